// ----- sv/rrts_pkg.sv -----
`timescale 1ns / 1ps

package rrts_pkg;

	localparam int OP_W   = 2;
	localparam int ID_W   = 3;
	localparam int TICK_W = 32;
	localparam int MASK_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_TICK        = 2'd0,
		OP_SELECT      = 2'd1,
		OP_SET_DELAY   = 2'd2,
		OP_CLEAR_DELAY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SEL,
		ST_DONE
	} state_t;

endpackage

// ----- sv/round_robin_task_selector_with_delays.sv -----
`timescale 1ns / 1ps

// Round-robin task selector with per-task delay counters.
// Input stream (s_*): tuser carries the operation (tick, select, set delay,
// clear delay); tdata carries the task index and the delay target. Every
// input transfer produces exactly one output transfer (m_*) with the running
// task in tdata and the no-eligible-task flag in tuser.
// The task run mask is written on the cfg_* channel, which is always ready;
// it is meant to be written only while no item is in flight.
// Set delay and clear delay go straight to the done state. A tick walks
// every task entry, and a select walks the ring from the task after the
// running one until a task qualifies or all TASK_COUNT entries are seen.
// The next item is taken in the idle state that follows the load of the
// result. Ticks and selects visit the task entries one per cycle through the
// single read port of the elapsed and target stores.
// One item is in flight at a time. A result waits in the output register
// while the receiver stalls; the next item is still taken, but its result is
// held back until the output register is free.
// Reset clears the running task to task 0, all delay marks and counts, and
// the run mask; no clearing pass is needed.
module round_robin_task_selector_with_delays #(
	parameter int TASK_COUNT = 8
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [rrts_pkg::MASK_W-1:0]                  cfg_data,  // task_run_mask
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// [2:0] task_id, [34:3] delay_ticks, [39:35] zero
	input  logic [39:0]                                  s_tdata,
	input  logic [rrts_pkg::OP_W-1:0]                    s_tuser,   // [1:0] operation
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	output logic [7:0]                                   m_tdata,   // [2:0] current_task
	output logic [0:0]                                   m_tuser    // [0] none_ready
);

	import rrts_pkg::*;

	localparam int IDW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int CW  = $clog2(TASK_COUNT + 1);
	localparam int MW  = (TASK_COUNT > MASK_W) ? TASK_COUNT : MASK_W;

	state_t state_q, state_d;

	logic [MASK_W-1:0]     mask_q;
	logic [MW-1:0]         mask_wide;
	logic [TASK_COUNT-1:0] mask_ext;
	logic [IDW-1:0]        running_q;
	logic [TASK_COUNT-1:0] delayed_q;
	logic [TASK_COUNT-1:0] evalid_q;
	logic [CW-1:0]         cnt_q;
	logic [IDW-1:0]        cand_q;
	logic [IDW-1:0]        cand_next;
	logic [IDW-1:0]        run_next;
	logic                  none_q;
	logic                  out_valid_q;
	logic [ID_W-1:0]       out_task_q;
	logic                  out_none_q;

	logic                  vld_s1;
	logic [IDW-1:0]        addr_s1;
	logic [TICK_W-1:0]     el_rd_s1;
	logic [TICK_W-1:0]     tg_rd_s1;

	logic [TICK_W-1:0]     elapsed_mem [TASK_COUNT];
	logic [TICK_W-1:0]     target_mem  [TASK_COUNT];

	logic [ID_W-1:0]       in_id;
	logic [TICK_W-1:0]     in_ticks;
	op_t                   in_op;
	logic                  in_xfer;
	logic                  id_ok;
	logic [IDW-1:0]        id_idx;
	logic                  walk_done;
	logic [IDW-1:0]        rd_addr;
	logic [TICK_W-1:0]     el_val;
	logic                  qualifies;

	logic                  issue;
	logic                  tick_wr;
	logic                  sel_hit;
	logic                  sel_miss;
	logic                  load_out;

	assign in_id    = s_tdata[ID_W-1:0];
	assign in_ticks = s_tdata[ID_W+TICK_W-1:ID_W];
	assign in_op    = op_t'(s_tuser);
	assign in_xfer  = s_tvalid && s_tready;
	assign id_ok    = 32'(in_id) < 32'(TASK_COUNT);
	assign id_idx   = IDW'(in_id);

	// Tasks at or above the mask width have no enable bit.
	assign mask_wide = MW'(mask_q);
	assign mask_ext  = mask_wide[TASK_COUNT-1:0];

	assign cand_next = (cand_q == IDW'(TASK_COUNT - 1)) ? '0 : IDW'(cand_q + 1'b1);
	assign run_next  = (running_q == IDW'(TASK_COUNT - 1)) ? '0 : IDW'(running_q + 1'b1);
	assign walk_done = cnt_q == CW'(TASK_COUNT);
	assign rd_addr   = (state_q == ST_TICK) ? cnt_q[IDW-1:0] : cand_q;

	// An elapsed entry that was never written since reset or since its task was last picked while delayed reads as zero.
	assign el_val    = evalid_q[addr_s1] ? el_rd_s1 : '0;
	assign qualifies = mask_ext[addr_s1] && (!delayed_q[addr_s1] || (el_val >= tg_rd_s1));

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = 8'(out_task_q);
	assign m_tuser   = out_none_q;

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		tick_wr  = 1'b0;
		sel_hit  = 1'b0;
		sel_miss = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_TICK: begin
				issue   = !walk_done;
				tick_wr = vld_s1 && delayed_q[addr_s1];
			end
			ST_SEL: begin
				sel_hit  = vld_s1 && qualifies;
				sel_miss = walk_done && !sel_hit;
				issue    = !walk_done && !sel_hit;
			end
			ST_DONE: begin
				load_out = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (in_op)
						OP_TICK:   state_d = ST_TICK;
						OP_SELECT: state_d = ST_SEL;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_TICK: begin
				if (walk_done) begin
					state_d = ST_DONE;
				end
			end
			ST_SEL: begin
				if (sel_hit || sel_miss) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			running_q   <= '0;
			delayed_q   <= '0;
			evalid_q    <= '0;
			cnt_q       <= '0;
			cand_q      <= '0;
			none_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (in_xfer) begin
				cnt_q  <= '0;
				cand_q <= run_next;
				none_q <= 1'b0;
				if (id_ok && (in_op == OP_SET_DELAY)) begin
					delayed_q[id_idx] <= 1'b1;
				end
				if (id_ok && (in_op == OP_CLEAR_DELAY)) begin
					delayed_q[id_idx] <= 1'b0;
				end
			end
			if (issue) begin
				cnt_q  <= CW'(cnt_q + 1'b1);
				cand_q <= cand_next;
			end
			if (tick_wr) begin
				evalid_q[addr_s1] <= 1'b1;
			end
			if (sel_hit) begin
				running_q <= addr_s1;
				// Only a delayed pick drops its counts; a free task keeps its elapsed count.
				if (delayed_q[addr_s1]) begin
					delayed_q[addr_s1] <= 1'b0;
					evalid_q[addr_s1]  <= 1'b0;
				end
			end
			if (sel_miss) begin
				none_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (load_out) begin
			out_task_q <= ID_W'(running_q);
			out_none_q <= none_q;
		end
	end

	// Elapsed and target stores: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (tick_wr) begin
			elapsed_mem[addr_s1] <= el_val + 1'b1;
		end
		el_rd_s1 <= elapsed_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_xfer && id_ok && (in_op == OP_SET_DELAY)) begin
			target_mem[id_idx] <= in_ticks;
		end
		tg_rd_s1 <= target_mem[rd_addr];
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(TASK_COUNT))
		else $error("walk counter ran past the ring");

	a_running_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		32'(running_q) < 32'(TASK_COUNT))
		else $error("running task outside the ring");

	a_pick_clears_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(sel_hit && delayed_q[addr_s1]) |=> !delayed_q[running_q] && !evalid_q[running_q])
		else $error("picked task still marked delayed");

	a_tick_keeps_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |=> $stable(delayed_q))
		else $error("delay marks changed during a tick walk");

	a_done_then_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && load_out) |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished item did not reach the output register");

endmodule
